FILE: rtl/qrs_pkg.sv
package qrs_pkg;

   localparam int unsigned SqrtSteps = 33;   // one result bit per pair of the 66-bit value
   localparam int unsigned DivSteps  = 49;   // quotient bits of |n| * 2^15 / |a|
   // input register, product, discriminant, sqrt, setup, divide, clamp, output
   localparam int unsigned Stages    = 3 + SqrtSteps + 1 + DivSteps + 1 + 1;

   localparam logic [1:0] STATUS_REAL      = 2'd0;
   localparam logic [1:0] STATUS_NEG_DISC  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_LEAD = 2'd2;

   localparam logic signed [31:0] MINUS_ONE_Q16 = -32'sd65536;
   localparam logic signed [31:0] Q16_MAX       = 32'sh7fffffff;
   localparam logic signed [31:0] Q16_MIN       = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] b;
      logic [31:0]        bm;
      logic [31:0]        am;
      logic [31:0]        cm;
      logic               a_neg;
      logic               ac_neg;
      logic               a_zero;
   } st1_type;

   typedef struct packed {
      logic signed [31:0] b;
      logic [31:0]        am;
      logic               a_neg;
      logic               ac_neg;
      logic               a_zero;
      logic [63:0]        b2;
      logic [63:0]        ac;
   } st2_type;

   typedef struct packed {
      logic signed [31:0] b;
      logic [31:0]        am;
      logic               a_neg;
      logic [1:0]         status;
      logic [65:0]        disc;
      logic [32:0]        root;
      logic [34:0]        rem;
   } sq_type;

   typedef struct packed {
      logic [31:0] am;
      logic [1:0]  status;
      logic [48:0] num0;
      logic [48:0] num1;
      logic [31:0] rem0;
      logic [31:0] rem1;
      logic        neg0;
      logic        neg1;
   } dv_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] q0;
      logic signed [31:0] q1;
      logic               sat;
   } fin_type;

endpackage

FILE: rtl/quadratic_root_solver.sv
// Quadratic root solver: solves a*t^2 + b*t + c = 0 for signed Q16.16 coefficients.
// Request channel: req_valid/req_stall with req_coef_a/b/c; a word is taken at a
// clock edge where req_valid is high and req_stall is low.
// Response channel: rsp_valid/rsp_stall with both roots, status and saturated flag.
// Configuration: csr_wr_en writes csr_wr_data into min_positive_root; write only
// while the pipeline is empty.
// Pipeline: 3 front stages, 33 square-root stages of one bit each, one setup
// stage, 49 divider stages of one quotient bit each for both roots in parallel,
// clamp stage, output register. Throughput: one word per cycle while the output
// is not stalled. The square-root and divide chains set the depth.
// Stall: while rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and clears
// min_positive_root to zero.
module quadratic_root_solver
   import qrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_coef_a,
   input  logic signed [31:0] req_coef_b,
   input  logic signed [31:0] req_coef_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_root_first,
   output logic signed [31:0] rsp_root_second,
   output logic [1:0]         rsp_status,
   output logic               rsp_saturated,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   logic [15:0]       min_root_ff;
   logic [Stages-1:0] vld_ff;
   logic              adv;

   assign adv       = !(vld_ff[Stages-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_root_ff <= '0;
      end else if (csr_wr_en) begin
         min_root_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Stages-2:0], req_valid};
      end
   end

   // stage 1: magnitudes and signs
   st1_type s1_ff, s1_in;
   always_comb begin
      s1_in.b      = req_coef_b;
      s1_in.bm     = req_coef_b[31] ? 32'(-req_coef_b) : 32'(req_coef_b);
      s1_in.am     = req_coef_a[31] ? 32'(-req_coef_a) : 32'(req_coef_a);
      s1_in.cm     = req_coef_c[31] ? 32'(-req_coef_c) : 32'(req_coef_c);
      s1_in.a_neg  = req_coef_a[31];
      s1_in.ac_neg = (req_coef_a[31] != req_coef_c[31]) && (req_coef_c != '0);
      s1_in.a_zero = (req_coef_a == '0);
   end

   // stage 2: b^2 and |a*c|
   st2_type s2_ff, s2_in;
   always_comb begin
      s2_in.b      = s1_ff.b;
      s2_in.am     = s1_ff.am;
      s2_in.a_neg  = s1_ff.a_neg;
      s2_in.ac_neg = s1_ff.ac_neg;
      s2_in.a_zero = s1_ff.a_zero;
      s2_in.b2     = s1_ff.bm * s1_ff.bm;
      s2_in.ac     = s1_ff.am * s1_ff.cm;
   end

   // stage 3: exact discriminant as Q34.32
   sq_type s3_ff, s3_in;
   logic   disc_neg;
   always_comb begin
      disc_neg     = 1'b0;
      s3_in.b      = s2_ff.b;
      s3_in.am     = s2_ff.am;
      s3_in.a_neg  = s2_ff.a_neg;
      s3_in.root   = '0;
      s3_in.rem    = '0;
      if (s2_ff.ac_neg) begin
         s3_in.disc = {2'b00, s2_ff.b2} + {s2_ff.ac, 2'b00};
      end else begin
         disc_neg   = s2_ff.ac > {2'b00, s2_ff.b2[63:2]};
         s3_in.disc = {2'b00, s2_ff.b2 - {s2_ff.ac[61:0], 2'b00}};
      end
      priority if (s2_ff.a_zero) s3_in.status = STATUS_ZERO_LEAD;
      else if (disc_neg)         s3_in.status = STATUS_NEG_DISC;
      else                       s3_in.status = STATUS_REAL;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   // square root, one result bit per stage, pairs taken from the top down
   sq_type sq_ff  [SqrtSteps];
   sq_type sq_src [SqrtSteps+1];
   assign sq_src[0] = s3_ff;

   for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
      localparam int unsigned Pos = 2 * (SqrtSteps - 1 - j);
      sq_type      sq_in;
      logic [36:0] rem_sh;
      logic [36:0] trial;
      logic        take;
      always_comb begin
         rem_sh = {sq_src[j].rem, sq_src[j].disc[Pos+1 -: 2]};
         trial  = {2'b00, sq_src[j].root, 2'b01};
         take   = rem_sh >= trial;
         sq_in  = sq_src[j];
         sq_in.rem  = take ? 35'(rem_sh - trial) : rem_sh[34:0];
         sq_in.root = {sq_src[j].root[31:0], take};
      end
      always_ff @(posedge clock) begin
         if (adv) sq_ff[j] <= sq_in;
      end
      assign sq_src[j+1] = sq_ff[j];
   end

   // setup: numerators -b +/- s, scaled by 2^15, as magnitude and sign
   dv_type             dv0_ff, dv0_in;
   logic signed [34:0] n0, n1;
   logic [33:0]        n0m, n1m;
   always_comb begin
      n0  = -35'(sq_src[SqrtSteps].b) + $signed({2'b00, sq_src[SqrtSteps].root});
      n1  = -35'(sq_src[SqrtSteps].b) - $signed({2'b00, sq_src[SqrtSteps].root});
      n0m = n0[34] ? 34'(-n0) : n0[33:0];
      n1m = n1[34] ? 34'(-n1) : n1[33:0];
      dv0_in.am     = sq_src[SqrtSteps].am;
      dv0_in.status = sq_src[SqrtSteps].status;
      dv0_in.num0   = {n0m, 15'b0};
      dv0_in.num1   = {n1m, 15'b0};
      dv0_in.rem0   = '0;
      dv0_in.rem1   = '0;
      dv0_in.neg0   = n0[34] ^ sq_src[SqrtSteps].a_neg;
      dv0_in.neg1   = n1[34] ^ sq_src[SqrtSteps].a_neg;
   end

   always_ff @(posedge clock) begin
      if (adv) dv0_ff <= dv0_in;
   end

   // restoring divide of both roots, one quotient bit per stage;
   // quotient bits shift into the numerator word as it empties
   dv_type dv_ff  [DivSteps];
   dv_type dv_src [DivSteps+1];
   assign dv_src[0] = dv0_ff;

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      dv_type      dv_in;
      logic [32:0] sh0, sh1, dvs;
      logic        ge0, ge1;
      always_comb begin
         dvs   = {1'b0, dv_src[k].am};
         sh0   = {dv_src[k].rem0, dv_src[k].num0[48]};
         sh1   = {dv_src[k].rem1, dv_src[k].num1[48]};
         ge0   = sh0 >= dvs;
         ge1   = sh1 >= dvs;
         dv_in = dv_src[k];
         dv_in.rem0 = ge0 ? 32'(sh0 - dvs) : sh0[31:0];
         dv_in.rem1 = ge1 ? 32'(sh1 - dvs) : sh1[31:0];
         dv_in.num0 = {dv_src[k].num0[47:0], ge0};
         dv_in.num1 = {dv_src[k].num1[47:0], ge1};
      end
      always_ff @(posedge clock) begin
         if (adv) dv_ff[k] <= dv_in;
      end
      assign dv_src[k+1] = dv_ff[k];
   end

   // sign and clamp to Q16.16
   fin_type     fin_ff, fin_in;
   logic [48:0] q0m, q1m;
   logic        neg0, neg1, sat0, sat1;
   always_comb begin
      q0m  = dv_src[DivSteps].num0;
      q1m  = dv_src[DivSteps].num1;
      neg0 = dv_src[DivSteps].neg0;
      neg1 = dv_src[DivSteps].neg1;
      sat0 = neg0 ? (q0m > 49'h0_8000_0000) : (q0m > 49'h0_7fff_ffff);
      sat1 = neg1 ? (q1m > 49'h0_8000_0000) : (q1m > 49'h0_7fff_ffff);
      fin_in.status = dv_src[DivSteps].status;
      if (sat0)      fin_in.q0 = neg0 ? Q16_MIN : Q16_MAX;
      else if (neg0) fin_in.q0 = -$signed(q0m[31:0]);
      else           fin_in.q0 = $signed(q0m[31:0]);
      if (sat1)      fin_in.q1 = neg1 ? Q16_MIN : Q16_MAX;
      else if (neg1) fin_in.q1 = -$signed(q1m[31:0]);
      else           fin_in.q1 = $signed(q1m[31:0]);
      fin_in.sat = sat0 | sat1;
   end

   always_ff @(posedge clock) begin
      if (adv) fin_ff <= fin_in;
   end

   // output register: ordering and special cases
   logic signed [31:0] first_ff, first_in, second_ff, second_in;
   logic [1:0]         status_ff;
   logic               sat_ff, sat_in, swap;
   always_comb begin
      swap = (fin_ff.q1 < fin_ff.q0) && (fin_ff.q1 > $signed({16'b0, min_root_ff}));
      if (fin_ff.status != STATUS_REAL) begin
         first_in  = MINUS_ONE_Q16;
         second_in = MINUS_ONE_Q16;
         sat_in    = 1'b0;
      end else begin
         first_in  = swap ? fin_ff.q1 : fin_ff.q0;
         second_in = swap ? fin_ff.q0 : fin_ff.q1;
         sat_in    = fin_ff.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         status_ff <= fin_ff.status;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_root_first  = first_ff;
   assign rsp_root_second = second_ff;
   assign rsp_status      = status_ff;
   assign rsp_saturated   = sat_ff;

   a_no_root_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_REAL |->
         rsp_root_first == MINUS_ONE_Q16 && rsp_root_second == MINUS_ONE_Q16 && !rsp_saturated)
      else $error("special case word carries root values");

   a_sat_has_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_root_first == Q16_MAX || rsp_root_first == Q16_MIN ||
         rsp_root_second == Q16_MAX || rsp_root_second == Q16_MIN)
      else $error("saturated flag without a clamped root");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

endmodule
